// ----- hw/rtl/pil_pkg.sv -----
// ----------------------------------------------------------------------------
// pil_pkg - shared definitions for the integer literal parser
// Parse phases, character codes and the digit decoder.
// ----------------------------------------------------------------------------
package pil_pkg;

	localparam int VALUE_BITS  = 64;   // result field width
	localparam int VALUE_WIDTH = 64;   // default accumulator width (8..64)

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_ZERO = 3'd1,
		PH_HEX  = 3'd2,
		PH_OCT  = 3'd3,
		PH_BIN  = 3'd4,
		PH_DEC  = 3'd5
	} phase_t;

	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_F  = 8'h46;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_F  = 8'h66;
	localparam logic [7:0] CH_UP_X  = 8'h58;
	localparam logic [7:0] CH_LO_X  = 8'h78;
	localparam logic [7:0] CH_UP_C  = 8'h43;
	localparam logic [7:0] CH_LO_C  = 8'h63;
	localparam logic [7:0] CH_UP_B  = 8'h42;
	localparam logic [7:0] CH_LO_B  = 8'h62;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_PLUS  = 8'h2b;

	localparam logic [4:0] BASE_HEX = 5'd16;
	localparam logic [4:0] BASE_DEC = 5'd10;
	localparam logic [4:0] BASE_OCT = 5'd8;
	localparam logic [4:0] BASE_BIN = 5'd2;

	typedef struct packed {
		logic       ok;   // character is a hex digit of any case
		logic [3:0] val;
	} digit_t;

	function automatic digit_t hex_digit(input logic [7:0] c);
		digit_t d;
		d.ok  = 1'b1;
		d.val = 4'd0;
		if (c inside {[CH_0:CH_9]}) begin
			d.val = 4'(c - CH_0);
		end else if (c inside {[CH_UP_A:CH_UP_F]}) begin
			d.val = 4'(c - CH_UP_A + 8'd10);
		end else if (c inside {[CH_LO_A:CH_LO_F]}) begin
			d.val = 4'(c - CH_LO_A + 8'd10);
		end else begin
			d.ok = 1'b0;
		end
		return d;
	endfunction

endpackage

// ----- hw/rtl/pil_if.sv -----
// ----------------------------------------------------------------------------
// pil_if - valid/ready channels of the integer literal parser
// Character channel in, result channel out.
// ----------------------------------------------------------------------------
interface pil_chr_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       first;

	modport source (output valid, output ch, output first, input ready);
	modport sink   (input valid, input ch, input first, output ready);
endinterface

interface pil_res_if;
	logic                             valid;
	logic                             ready;
	logic signed [pil_pkg::VALUE_BITS-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

// ----- hw/rtl/pil_step.sv -----
// ----------------------------------------------------------------------------
// pil_step - one parse step
// Next phase, accumulator and sign for one character; flags a finished literal.
// ----------------------------------------------------------------------------
module pil_step #(
	parameter int W = pil_pkg::VALUE_WIDTH
) (
	input  logic [7:0]        ch,
	input  logic              first,
	input  pil_pkg::phase_t   phase,
	input  logic [W-1:0]      accum,
	input  logic              negative,
	output pil_pkg::phase_t   phase_nxt,
	output logic [W-1:0]      accum_nxt,
	output logic              negative_nxt,
	output logic              emit,
	output logic [W-1:0]      emit_val
);

	pil_pkg::digit_t dig;
	logic [4:0]      base;
	logic [2:0]      sh;
	logic            in_base;

	assign dig     = pil_pkg::hex_digit(ch);
	assign in_base = dig.ok && ({1'b0, dig.val} < base);

	// radix of the active phase
	always_comb begin
		case (phase)
			pil_pkg::PH_HEX: begin base = pil_pkg::BASE_HEX; sh = 3'd4; end
			pil_pkg::PH_BIN: begin base = pil_pkg::BASE_BIN; sh = 3'd1; end
			pil_pkg::PH_DEC: begin base = pil_pkg::BASE_DEC; sh = 3'd0; end
			default:         begin base = pil_pkg::BASE_OCT; sh = 3'd3; end
		endcase
	end

	always_comb begin
		phase_nxt    = phase;
		accum_nxt    = accum;
		negative_nxt = negative;
		emit         = 1'b0;
		emit_val     = '0;
		if (first) begin
			accum_nxt    = '0;
			negative_nxt = 1'b0;
			if (ch == pil_pkg::CH_0) begin
				phase_nxt = pil_pkg::PH_ZERO;
			end else if (ch inside {[pil_pkg::CH_1:pil_pkg::CH_9]}) begin
				accum_nxt = W'(dig.val);
				phase_nxt = pil_pkg::PH_DEC;
			end else if (ch == pil_pkg::CH_MINUS) begin
				negative_nxt = 1'b1;
				phase_nxt    = pil_pkg::PH_DEC;
			end else if (ch == pil_pkg::CH_PLUS) begin
				phase_nxt = pil_pkg::PH_DEC;
			end else begin
				emit      = 1'b1;
				phase_nxt = pil_pkg::PH_IDLE;
			end
		end else begin
			case (phase)
				pil_pkg::PH_ZERO: begin
					if (ch == pil_pkg::CH_LO_X || ch == pil_pkg::CH_UP_X) begin
						phase_nxt = pil_pkg::PH_HEX;
					end else if (ch == pil_pkg::CH_LO_C || ch == pil_pkg::CH_UP_C) begin
						phase_nxt = pil_pkg::PH_OCT;
					end else if (ch == pil_pkg::CH_LO_B || ch == pil_pkg::CH_UP_B) begin
						phase_nxt = pil_pkg::PH_BIN;
					end else if (in_base) begin
						accum_nxt = W'(dig.val);
						phase_nxt = pil_pkg::PH_OCT;
					end else begin
						emit      = 1'b1;
						phase_nxt = pil_pkg::PH_IDLE;
					end
				end
				pil_pkg::PH_HEX, pil_pkg::PH_OCT, pil_pkg::PH_BIN: begin
					if (in_base) begin
						accum_nxt = (accum << sh) + W'(dig.val);
					end else begin
						emit      = 1'b1;
						emit_val  = accum;
						phase_nxt = pil_pkg::PH_IDLE;
					end
				end
				pil_pkg::PH_DEC: begin
					if (in_base) begin
						// x10 as x8 + x2
						accum_nxt = (accum << 3) + (accum << 1) + W'(dig.val);
					end else begin
						emit      = 1'b1;
						emit_val  = negative ? W'(-accum) : accum;
						phase_nxt = pil_pkg::PH_IDLE;
					end
				end
				default: begin
					phase_nxt = phase;
				end
			endcase
		end
	end

endmodule

// ----- hw/rtl/parse_integer_literal.sv -----
// ----------------------------------------------------------------------------
// parse_integer_literal - streaming integer literal parser
// Takes a literal one character per word (hex 0x, octal 0c or leading 0,
// binary 0b, else signed decimal) and returns its value, sign-extended to
// 64 bits, when the terminating character arrives.
// ----------------------------------------------------------------------------
//
//   channel | role  | word fields                 | handshake
//   --------+-------+-----------------------------+-------------
//   chr     | sink  | ch[7:0], first              | valid/ready
//   result  | src   | value[63:0] signed          | valid/ready
//
// One character word per cycle, sustained unless a terminator meets a full
// result register. Input register -> step logic (one shift-add, or a x10
// shift-add for decimal) -> result register: the terminating character is
// held in the input register, then its result is loaded into the result register.
// Reset (arst_n low) returns the parser to idle with no result pending.
// A full result register stalls only a character that ends a literal;
// characters that merely extend the accumulator keep flowing.
// ----------------------------------------------------------------------------
module parse_integer_literal #(
	parameter int VALUE_WIDTH = pil_pkg::VALUE_WIDTH
) (
	input  logic       clk,
	input  logic       arst_n,
	pil_chr_if.sink    chr,
	pil_res_if.source  result
);

	// input register
	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       first_s1;

	// parse state
	pil_pkg::phase_t          phase_q;
	logic [VALUE_WIDTH-1:0]   accum_q;
	logic                     negative_q;

	// result register
	logic                                  res_valid_q;
	logic signed [pil_pkg::VALUE_BITS-1:0] res_value_q;

	// step outputs
	pil_pkg::phase_t          phase_nxt;
	logic [VALUE_WIDTH-1:0]   accum_nxt;
	logic                     negative_nxt;
	logic                     emit;
	logic [VALUE_WIDTH-1:0]   emit_val;

	logic advance;

	pil_step #(
		.W (VALUE_WIDTH)
	) u_step (
		.ch           (ch_s1),
		.first        (first_s1),
		.phase        (phase_q),
		.accum        (accum_q),
		.negative     (negative_q),
		.phase_nxt    (phase_nxt),
		.accum_nxt    (accum_nxt),
		.negative_nxt (negative_nxt),
		.emit         (emit),
		.emit_val     (emit_val)
	);

	// the held word moves on unless it needs the result slot and that is full
	assign advance   = valid_s1 && (!emit || !res_valid_q || result.ready);
	assign chr.ready = !valid_s1 || advance;

	assign result.valid = res_valid_q;
	assign result.value = res_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chr.ready) begin
			valid_s1 <= chr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chr.valid && chr.ready) begin
			ch_s1    <= chr.ch;
			first_s1 <= chr.first;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= pil_pkg::PH_IDLE;
			accum_q    <= '0;
			negative_q <= 1'b0;
		end else if (advance) begin
			phase_q    <= phase_nxt;
			accum_q    <= accum_nxt;
			negative_q <= negative_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && emit) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// sign-extend from the accumulator width
	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_value_q <= pil_pkg::VALUE_BITS'($signed(emit_val));
		end
	end

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb - self-checking bench for parse_integer_literal
// Streams character words (directed table, then random literals of every
// radix, restarts and noise) under random gaps and stalls on both channels,
// and checks every returned value against an in-bench parser model or a typed table value.
// ----------------------------------------------------------------------------
module tb;
	import pil_pkg::*;

	localparam int          ACC_W       = VALUE_WIDTH;
	localparam logic [63:0] ACC_MASK    = {64{1'b1}} >> (64 - ACC_W);
	localparam logic [63:0] ACC_SIGN    = 64'd1 << (ACC_W - 1);
	localparam int          LIMIT       = 400000;   // cycles before giving up
	localparam int          HOLD_CYCLES = 300;      // long receiver hold-off
	localparam int          WORDS_PER_PHASE = 384;

	// Directed row: character word, plus the value it ends with where that is
	// obvious by inspection (typed = 1). Other rows lean on the parser model.
	typedef struct packed {
		logic [7:0]  ch;
		logic        first;
		logic        typed;
		logic [63:0] want;
	} dir_row_t;

	localparam int N_DIR = 25;

	logic clk;
	logic arst_n;

	pil_chr_if chr_bus ();
	pil_res_if res_bus ();

	parse_integer_literal #(.VALUE_WIDTH(ACC_W)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.chr    (chr_bus),
		.result (res_bus)
	);

	// Parser model state
	phase_t      lit_phase;
	logic [63:0] lit_acc;
	logic        lit_neg;

	logic [63:0] pending_values[$];   // values still owed by the block

	// Typed expectation for the word currently on the character channel
	logic        cur_typed;
	logic [63:0] cur_want;

	int src_idle;      // sender gap chance, percent
	int snk_idle;      // receiver stall chance, percent
	bit hold_req;      // ask the receiver for a long hold-off
	int hold_left;
	int n_holds;
	int n_words;       // accepted words that the parser did not ignore
	int n_results;
	int n_literals;
	int n_bad;
	int cycles;

	dir_row_t dir_tab [0:N_DIR-1] = '{
		'{"7",      1'b0, 1'b0, 64'd0},          // idle, no first: ignored
		'{8'hFF,    1'b1, 1'b1, 64'd0},          // bad first char
		'{CH_0,     1'b1, 1'b0, 64'd0},
		'{CH_LO_X,  1'b0, 1'b0, 64'd0},
		'{CH_LO_F,  1'b0, 1'b0, 64'd0},
		'{8'h00,    1'b0, 1'b1, 64'd15},         // NUL ends 0xf
		'{CH_0,     1'b1, 1'b0, 64'd0},
		'{CH_UP_B,  1'b0, 1'b0, 64'd0},
		'{CH_1,     1'b0, 1'b0, 64'd0},
		'{"2",      1'b0, 1'b1, 64'd1},          // '2' is no binary digit
		'{CH_0,     1'b1, 1'b0, 64'd0},
		'{CH_LO_C,  1'b0, 1'b0, 64'd0},
		'{"g",      1'b0, 1'b1, 64'd0},          // 0c with no digits
		'{CH_0,     1'b1, 1'b0, 64'd0},
		'{"7",      1'b0, 1'b0, 64'd0},          // lone zero: octal
		'{"8",      1'b0, 1'b1, 64'd7},
		'{CH_0,     1'b1, 1'b0, 64'd0},
		'{"z",      1'b0, 1'b1, 64'd0},          // bare zero
		'{CH_MINUS, 1'b1, 1'b0, 64'd0},
		'{CH_9,     1'b0, 1'b0, 64'd0},
		'{" ",      1'b0, 1'b1, -64'sd9},
		'{CH_PLUS,  1'b1, 1'b0, 64'd0},
		'{"4",      1'b0, 1'b0, 64'd0},
		'{"3",      1'b1, 1'b0, 64'd0},          // restart drops +4
		'{";",      1'b0, 1'b1, 64'd3}
	};

	// ------------------------------------------------------------------------
	// Parser model
	// ------------------------------------------------------------------------

	// Digit value of c in the given radix, -1 if it is not one
	function automatic int char_digit(input logic [7:0] c, input int radix);
		int d;
		d = -1;
		if (c >= CH_0 && c <= CH_9) begin
			d = int'(c) - int'(CH_0);
		end else if (c >= CH_UP_A && c <= CH_UP_F) begin
			d = int'(c) - int'(CH_UP_A) + 10;
		end else if (c >= CH_LO_A && c <= CH_LO_F) begin
			d = int'(c) - int'(CH_LO_A) + 10;
		end
		if (d >= radix) begin
			d = -1;
		end
		return d;
	endfunction

	// Accumulator (ACC_W bits) sign-extended to the 64-bit result field
	function automatic logic [63:0] acc_to_value(input logic [63:0] a);
		logic [63:0] m;
		m = a & ACC_MASK;
		return (m ^ ACC_SIGN) - ACC_SIGN;
	endfunction

	task automatic parse_char(input logic [7:0] c, input logic f,
			output bit emits, output logic [63:0] v);
		int d;
		int radix;
		int sh;
		emits = 1'b0;
		v     = '0;
		if (f) begin
			lit_acc = '0;
			lit_neg = 1'b0;
			if (c == CH_0) begin
				lit_phase = PH_ZERO;
			end else if (c >= CH_1 && c <= CH_9) begin
				lit_acc   = 64'(c - CH_0);
				lit_phase = PH_DEC;
			end else if (c == CH_MINUS) begin
				lit_neg   = 1'b1;
				lit_phase = PH_DEC;
			end else if (c == CH_PLUS) begin
				lit_phase = PH_DEC;
			end else begin
				emits     = 1'b1;
				lit_phase = PH_IDLE;
			end
		end else begin
			case (lit_phase)
				PH_ZERO: begin
					if (c == CH_LO_X || c == CH_UP_X) begin
						lit_phase = PH_HEX;
					end else if (c == CH_LO_C || c == CH_UP_C) begin
						lit_phase = PH_OCT;
					end else if (c == CH_LO_B || c == CH_UP_B) begin
						lit_phase = PH_BIN;
					end else begin
						d = char_digit(c, BASE_OCT);
						if (d < 0) begin
							emits     = 1'b1;
							lit_phase = PH_IDLE;
						end else begin
							lit_acc   = 64'(d);
							lit_phase = PH_OCT;
						end
					end
				end
				PH_HEX, PH_OCT, PH_BIN: begin
					radix = (lit_phase == PH_HEX) ? BASE_HEX :
						(lit_phase == PH_OCT) ? BASE_OCT : BASE_BIN;
					sh    = (lit_phase == PH_HEX) ? 4 : (lit_phase == PH_OCT) ? 3 : 1;
					d     = char_digit(c, radix);
					if (d < 0) begin
						emits     = 1'b1;
						v         = acc_to_value(lit_acc);
						lit_phase = PH_IDLE;
					end else begin
						lit_acc = ((lit_acc << sh) + 64'(d)) & ACC_MASK;
					end
				end
				PH_DEC: begin
					d = char_digit(c, BASE_DEC);
					if (d < 0) begin
						emits     = 1'b1;
						v         = acc_to_value(lit_neg ? -lit_acc : lit_acc);
						lit_phase = PH_IDLE;
					end else begin
						lit_acc = (lit_acc * 64'd10 + 64'(d)) & ACC_MASK;
					end
				end
				default: ;   // idle: word dropped
			endcase
		end
	endtask

	task automatic report_bad(input bit stray, input logic [63:0] want,
			input logic [63:0] got);
		n_bad++;
		if (n_bad <= 10) begin
			if (stray) begin
				$display("ERROR: value %h with no result owed", got);
			end else begin
				$display("ERROR: value mismatch, expected %h got %h", want, got);
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Clock, timeout
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timed out after %0d cycles, %0d values still owed",
			cycles, pending_values.size());
		$display("FAILURE");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Monitor: both channels sampled at the falling edge, where every signal
	// is settled; a handshake seen here completes at the next rising edge.
	// Input side first so a word and its own result never race.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		bit          emits;
		logic [63:0] v;
		logic [63:0] w;
		if (arst_n) begin
			if (chr_bus.valid && chr_bus.ready) begin
				if (lit_phase != PH_IDLE || chr_bus.first) begin
					n_words++;
				end
				parse_char(chr_bus.ch, chr_bus.first, emits, v);
				if (emits) begin
					pending_values.push_back(cur_typed ? cur_want : v);
				end
			end
			if (res_bus.valid && res_bus.ready) begin
				n_results++;
				if (pending_values.size() == 0) begin
					report_bad(1'b1, '0, res_bus.value);
				end else begin
					w = pending_values.pop_front();
					if (w !== res_bus.value) begin
						report_bad(1'b0, w, res_bus.value);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: random stalls, plus one long hold-off on request so that the
	// result register fills and the parser backs up on a terminator.
	// ------------------------------------------------------------------------
	initial begin
		res_bus.ready = 1'b0;
		hold_left     = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				res_bus.ready <= 1'b0;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				n_holds++;
				res_bus.ready <= 1'b0;
			end else begin
				res_bus.ready <= ($urandom_range(0, 99) >= snk_idle);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sender
	// ------------------------------------------------------------------------

	// Offer one word; returns at the rising edge that accepts it. valid only
	// drops in a gap, so it is never lowered and raised in one step.
	task automatic send_word(input logic [7:0] c, input logic f,
			input logic typed, input logic [63:0] want);
		if ($urandom_range(0, 99) < src_idle) begin
			chr_bus.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < src_idle);
		end
		cur_typed = typed;
		cur_want  = want;
		chr_bus.valid <= 1'b1;
		chr_bus.ch    <= c;
		chr_bus.first <= f;
		do @(negedge clk); while (!chr_bus.ready);
		@(posedge clk);
	endtask

	// One random literal, mostly well formed: prefix, digits of the radix in
	// random case, then a terminator. Some are cut short (the next first=1
	// drops them), some start on a bad char, some are plain noise.
	task automatic send_literal();
		int          kind;
		int          ndig;
		int          radix;
		int          maxlen;
		int          d;
		int          i;
		bit          lone;
		logic [7:0]  c;
		kind = $urandom_range(0, 99);
		lone = (kind >= 34 && kind < 44);
		if (kind >= 92) begin
			repeat ($urandom_range(1, 6)) begin
				send_word(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0,
					1'b0, '0);
			end
			return;
		end
		if (kind >= 86) begin
			do c = 8'($urandom_range(0, 255));
			while ((c >= CH_0 && c <= CH_9) || c == CH_MINUS || c == CH_PLUS);
			send_word(c, 1'b1, 1'b0, '0);
			return;
		end
		n_literals++;
		if (kind < 44) begin
			send_word(CH_0, 1'b1, 1'b0, '0);
			if (kind < 12) begin
				radix  = BASE_HEX;
				maxlen = 20;
				send_word($urandom_range(0, 1) ? CH_LO_X : CH_UP_X, 1'b0, 1'b0, '0);
			end else if (kind < 22) begin
				radix  = BASE_OCT;
				maxlen = 26;
				send_word($urandom_range(0, 1) ? CH_LO_C : CH_UP_C, 1'b0, 1'b0, '0);
			end else if (kind < 34) begin
				radix  = BASE_BIN;
				maxlen = 70;
				send_word($urandom_range(0, 1) ? CH_LO_B : CH_UP_B, 1'b0, 1'b0, '0);
			end else begin
				radix  = BASE_OCT;   // lone zero, digits follow directly
				maxlen = 26;
			end
		end else begin
			radix  = BASE_DEC;
			maxlen = 24;
			if (kind < 70) begin
				send_word(8'(CH_0 + $urandom_range(1, 9)), 1'b1, 1'b0, '0);
			end else if (kind < 80) begin
				send_word(CH_MINUS, 1'b1, 1'b0, '0);
			end else begin
				send_word(CH_PLUS, 1'b1, 1'b0, '0);
			end
		end
		// mostly short; now and then long enough to wrap the accumulator
		ndig = ($urandom_range(0, 11) == 0) ? $urandom_range(8, maxlen)
			: $urandom_range(0, 5);
		for (i = 0; i < ndig; i++) begin
			d = $urandom_range(0, radix - 1);
			if (d < 10) begin
				c = 8'(CH_0 + d);
			end else begin
				c = 8'(($urandom_range(0, 1) ? CH_LO_A : CH_UP_A) + d - 10);
			end
			send_word(c, 1'b0, 1'b0, '0);
			if ($urandom_range(0, 39) == 0) begin
				return;
			end
		end
		// after a bare zero a prefix letter would pick a radix, not end it
		do c = 8'($urandom_range(0, 255));
		while (char_digit(c, radix) >= 0 || (lone && ndig == 0 &&
			(c == CH_LO_X || c == CH_UP_X || c == CH_LO_C || c == CH_UP_C ||
			 c == CH_LO_B || c == CH_UP_B)));
		send_word(c, 1'b0, 1'b0, '0);
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		int  goal;
		int  mid;
		bit  paused;
		arst_n        = 1'b0;
		chr_bus.valid = 1'b0;
		chr_bus.ch    = '0;
		chr_bus.first = 1'b0;
		cur_typed     = 1'b0;
		cur_want      = '0;
		lit_phase     = PH_IDLE;
		lit_acc       = '0;
		lit_neg       = 1'b0;
		src_idle      = 0;
		snk_idle      = 0;
		hold_req      = 1'b0;
		n_holds       = 0;
		n_words       = 0;
		n_results     = 0;
		n_literals    = 0;
		n_bad         = 0;
		paused        = 1'b0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every radix, signs, restart, idle words
		for (int k = 0; k < N_DIR; k++) begin
			send_word(dir_tab[k].ch, dir_tab[k].first, dir_tab[k].typed,
				dir_tab[k].want);
		end

		// Phase 1: sender gaps 30 %, receiver stalls 53 %, one long hold-off
		src_idle = 30;
		snk_idle = 53;
		goal     = n_words + WORDS_PER_PHASE;
		mid      = n_words + WORDS_PER_PHASE / 2;
		while (n_words < goal) begin
			send_literal();
			if (n_holds == 0 && !hold_req && n_words >= mid) begin
				hold_req = 1'b1;
			end
		end

		// Phase 2: the other way round, with one pause until fully drained
		src_idle = 53;
		snk_idle = 30;
		goal     = n_words + WORDS_PER_PHASE;
		mid      = n_words + WORDS_PER_PHASE / 2;
		while (n_words < goal) begin
			send_literal();
			if (!paused && n_words >= mid) begin
				paused = 1'b1;
				chr_bus.valid <= 1'b0;
				do @(posedge clk); while (pending_values.size() != 0);
			end
		end

		// Phase 3: back to back on both sides
		src_idle = 0;
		snk_idle = 0;
		goal     = n_words + WORDS_PER_PHASE;
		while (n_words < goal) begin
			send_literal();
		end

		chr_bus.valid <= 1'b0;
		do @(posedge clk); while (pending_values.size() != 0);
		repeat (20) @(posedge clk);   // catch any stray late result

		$display("Sent %0d parsed words in %0d literals (hex, octal, binary, decimal,",
			n_words, n_literals);
		$display("  signs, restarts, noise); %0d values checked, %0d errors, %0d hold-offs",
			n_results, n_bad, n_holds);
		if (n_bad == 0 && pending_values.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/pil_pkg.sv
hw/rtl/pil_if.sv
hw/rtl/pil_step.sv
hw/rtl/parse_integer_literal.sv
dv/tb.sv
